@@ hdl/vfc_pkg.sv @@
package vfc_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = 13;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned ERR_W   = 20;
  localparam int unsigned PEN_W   = 12;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned OUT_DATA_W = 32;

  // Default geometry
  localparam int unsigned LINE_PIXELS_DEF  = 80;
  localparam int unsigned FRAME_LINES_DEF  = 60;
  localparam int unsigned PACKET_BYTES_DEF = 164;

  // First pixel byte of a packet
  localparam logic [BYTE_W-1:0] PIX_FIRST_BYTE = 8'd4;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_READ   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_OFF    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_SETTLE = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAD_LINE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_WAIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd4;

  // Register reset values
  localparam logic [ERR_W-1:0]  ERROR_LIMIT_RST = 20'd300000;
  localparam logic [PEN_W-1:0]  BAD_LINE_RST    = 12'd1000;
  localparam logic [TICK_W-1:0] IDLE_WAIT_RST   = 16'd100;
  localparam logic [TICK_W-1:0] OFF_TIME_RST    = 16'd3000;
  localparam logic [TICK_W-1:0] SETTLE_RST      = 16'd50;

  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

  typedef struct packed {
    logic [ERR_W-1:0]  error_limit;
    logic [PEN_W-1:0]  bad_line_penalty;
    logic [TICK_W-1:0] idle_wait_ms;
    logic [TICK_W-1:0] off_time_ms;
    logic [TICK_W-1:0] settle_ms;
  } cfg_t;

  typedef struct packed {
    logic               pixel_write;
    logic [ADDR_W-1:0]  pixel_addr;
    logic [PIX_W-1:0]   pixel_value;
    logic               frame_done;
    logic               power_on;
    logic [PHASE_W-1:0] phase;
  } res_t;

endpackage

@@ hdl/vfc_cfg_regs.sv @@
module vfc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vfc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output vfc_pkg::cfg_t                     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.error_limit      <= vfc_pkg::ERROR_LIMIT_RST;
      cfg.bad_line_penalty <= vfc_pkg::BAD_LINE_RST;
      cfg.idle_wait_ms     <= vfc_pkg::IDLE_WAIT_RST;
      cfg.off_time_ms      <= vfc_pkg::OFF_TIME_RST;
      cfg.settle_ms        <= vfc_pkg::SETTLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vfc_pkg::REG_ERROR_LIMIT: cfg.error_limit <= cfg_data[vfc_pkg::ERR_W-1:0];
        vfc_pkg::REG_BAD_LINE:    cfg.bad_line_penalty <= cfg_data[vfc_pkg::PEN_W-1:0];
        vfc_pkg::REG_IDLE_WAIT:   cfg.idle_wait_ms <= cfg_data[vfc_pkg::TICK_W-1:0];
        vfc_pkg::REG_OFF_TIME:    cfg.off_time_ms <= cfg_data[vfc_pkg::TICK_W-1:0];
        vfc_pkg::REG_SETTLE:      cfg.settle_ms <= cfg_data[vfc_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/vfc_core.sv @@
module vfc_core #(
  parameter int unsigned LINE_PIXELS  = vfc_pkg::LINE_PIXELS_DEF,
  parameter int unsigned FRAME_LINES  = vfc_pkg::FRAME_LINES_DEF,
  parameter int unsigned PACKET_BYTES = vfc_pkg::PACKET_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          mode,
  input  logic [vfc_pkg::BYTE_W-1:0]    spi_byte,
  input  vfc_pkg::cfg_t                 cfg,
  output vfc_pkg::res_t                 res
);

  localparam logic [vfc_pkg::BYTE_W-1:0] PKT_LAST  = vfc_pkg::BYTE_W'(PACKET_BYTES - 1);
  localparam logic [vfc_pkg::BYTE_W-1:0] LINES     = vfc_pkg::BYTE_W'(FRAME_LINES);
  localparam logic [vfc_pkg::BYTE_W-1:0] LAST_LINE = vfc_pkg::BYTE_W'(FRAME_LINES - 1);
  localparam logic [vfc_pkg::BYTE_W-1:0] COLS      = vfc_pkg::BYTE_W'(LINE_PIXELS);
  localparam logic [vfc_pkg::ADDR_W-1:0] COLS_A    = vfc_pkg::ADDR_W'(LINE_PIXELS);

  logic [vfc_pkg::PHASE_W-1:0] phase_reg, phase_next;
  logic [vfc_pkg::BYTE_W-1:0]  byte_index, byte_index_next;
  logic [vfc_pkg::BYTE_W-1:0]  line_number, line_number_next;
  logic                        discard_packet, discard_packet_next;
  logic [vfc_pkg::BYTE_W-1:0]  high_byte, high_byte_next;
  logic [vfc_pkg::ERR_W-1:0]   error_count, error_count_next;
  logic [vfc_pkg::TICK_W-1:0]  tick_count, tick_count_next;
  logic                        power_reg, power_reg_next;

  logic [vfc_pkg::TICK_W-1:0]  tick_limit;
  logic                        tick_end;
  logic [vfc_pkg::BYTE_W-1:0]  pix_off;
  logic [vfc_pkg::BYTE_W-2:0]  col;
  logic                        bad_line;
  logic [vfc_pkg::ERR_W:0]     err_sum;
  logic                        wr;
  logic [vfc_pkg::ADDR_W-1:0]  addr;
  logic [vfc_pkg::PIX_W-1:0]   val;
  logic                        done;

  // Limit of the running timed phase
  always_comb begin
    case (phase_reg)
      vfc_pkg::PH_IDLE:   tick_limit = cfg.idle_wait_ms;
      vfc_pkg::PH_OFF:    tick_limit = cfg.off_time_ms;
      vfc_pkg::PH_SETTLE: tick_limit = cfg.settle_ms;
      default:            tick_limit = cfg.idle_wait_ms;
    endcase
  end

  assign tick_end = (tick_count >= tick_limit);
  assign pix_off  = byte_index - vfc_pkg::PIX_FIRST_BYTE;
  assign col      = pix_off[vfc_pkg::BYTE_W-1:1];
  assign bad_line = !discard_packet && (line_number >= LINES);
  // penalty then +1, each saturating, equals one saturating add of both
  assign err_sum  = {1'b0, error_count}
                  + (bad_line ? (vfc_pkg::ERR_W+1)'(cfg.bad_line_penalty) : '0)
                  + (vfc_pkg::ERR_W+1)'(1);

  always_comb begin
    phase_next          = phase_reg;
    byte_index_next     = byte_index;
    line_number_next    = line_number;
    discard_packet_next = discard_packet;
    high_byte_next      = high_byte;
    error_count_next    = error_count;
    tick_count_next     = tick_count;
    power_reg_next      = power_reg;
    wr   = 1'b0;
    addr = '0;
    val  = '0;
    done = 1'b0;

    if (mode) begin
      if (phase_reg != vfc_pkg::PH_READ) begin
        if (tick_end) begin
          tick_count_next = '0;
          case (phase_reg)
            vfc_pkg::PH_OFF: begin
              power_reg_next = 1'b1;
              phase_next     = vfc_pkg::PH_SETTLE;
            end
            default: begin
              phase_next      = vfc_pkg::PH_READ;
              byte_index_next = '0;
            end
          endcase
        end else begin
          tick_count_next = tick_count + vfc_pkg::TICK_W'(1);
        end
      end
    end else if (phase_reg == vfc_pkg::PH_READ) begin
      if (byte_index == '0 && error_count > cfg.error_limit) begin
        error_count_next = '0;
        tick_count_next  = '0;
        power_reg_next   = 1'b0;
        phase_next       = vfc_pkg::PH_OFF;
      end else begin
        if (byte_index == vfc_pkg::BYTE_W'(0)) begin
          discard_packet_next = &spi_byte[3:0];
        end else if (byte_index == vfc_pkg::BYTE_W'(1)) begin
          line_number_next = spi_byte;
        end else if (byte_index >= vfc_pkg::PIX_FIRST_BYTE) begin
          if (!pix_off[0]) begin
            high_byte_next = spi_byte;
          end else if (!discard_packet && line_number < LINES && {1'b0, col} < COLS) begin
            wr   = 1'b1;
            addr = vfc_pkg::ADDR_W'(line_number) * COLS_A + vfc_pkg::ADDR_W'(col);
            val  = {high_byte, spi_byte};
          end
        end

        if (byte_index >= PKT_LAST) begin
          byte_index_next  = '0;
          error_count_next = err_sum[vfc_pkg::ERR_W] ? vfc_pkg::ERR_MAX
                                                     : err_sum[vfc_pkg::ERR_W-1:0];
          if (!discard_packet && line_number == LAST_LINE) begin
            error_count_next = '0;
            done             = 1'b1;
            tick_count_next  = '0;
            phase_next       = vfc_pkg::PH_IDLE;
          end
        end else begin
          byte_index_next = byte_index + vfc_pkg::BYTE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= vfc_pkg::PH_READ;
      byte_index     <= '0;
      line_number    <= '0;
      discard_packet <= 1'b0;
      high_byte      <= '0;
      error_count    <= '0;
      tick_count     <= '0;
      power_reg      <= 1'b1;
    end else if (accept) begin
      phase_reg      <= phase_next;
      byte_index     <= byte_index_next;
      line_number    <= line_number_next;
      discard_packet <= discard_packet_next;
      high_byte      <= high_byte_next;
      error_count    <= error_count_next;
      tick_count     <= tick_count_next;
      power_reg      <= power_reg_next;
    end
  end

  always_comb begin
    res.pixel_write = wr;
    res.pixel_addr  = addr;
    res.pixel_value = val;
    res.frame_done  = done;
    res.power_on    = power_reg_next;
    res.phase       = phase_next;
  end

`ifndef ASSERT_OFF
  // camera is unpowered exactly while in the power-off phase
  a_power_phase: assert property (@(posedge clk) disable iff (rst)
    (power_reg == 1'b0) == (phase_reg == vfc_pkg::PH_OFF))
    else $error("power level and phase disagree");

  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= PKT_LAST)
    else $error("byte index past packet end");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> phase_reg == vfc_pkg::PH_IDLE && error_count == '0)
    else $error("frame end did not enter idle wait");

  a_tick_no_write: assert property (@(posedge clk) disable iff (rst)
    accept && mode |-> !wr && !done)
    else $error("tick produced a pixel write or frame end");
`endif

endmodule

@@ hdl/vfc_out_reg.sv @@
module vfc_out_reg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  output logic                                  load_ready,
  input  vfc_pkg::res_t                         res,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [vfc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);

  vfc_pkg::res_t held;

  // free when empty or when the held transaction leaves this cycle
  assign load_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_ready) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      held <= res;
    end
  end

  assign m_axis_tdata = {held.phase, held.power_on, held.pixel_value, held.pixel_addr};
  assign m_axis_tuser = held.pixel_write;
  assign m_axis_tlast = held.frame_done;

endmodule

@@ hdl/thermal_vospi_frame_capture_unit.sv @@
// Thermal camera video-port frame capture.
//
// Input stream (s_axis_*): one transaction per received SPI byte or per
// millisecond tick; s_axis_tuser selects which (0 byte, 1 tick).
// Bytes are grouped into fixed-length packets; byte 1 carries the line,
// big-endian pixel pairs follow from byte 4. Packets with a low nibble of
// 0xF in byte 0 are dropped.
// Output stream (m_axis_*): exactly one transaction per input transaction,
// carrying an optional frame-store write (tuser high), the camera power
// level and the phase as updated by it; tlast marks the end of the last line.
// Config channel (cfg_*): register writes by index, always ready; write
// only while no transactions are in flight.
// Timing: output valid follows input accept in the next cycle. Throughput: one
// transaction per clock while m_axis_tready is high, set by the single output register.
// Stall: while the output register holds an untaken transaction,
// s_axis_tready drops; nothing is lost or repeated.
// Reset: camera powered, reading phase at packet byte 0, error count
// cleared, registers at their defaults, output empty.
module thermal_vospi_frame_capture_unit #(
  parameter int unsigned LINE_PIXELS  = vfc_pkg::LINE_PIXELS_DEF,
  parameter int unsigned FRAME_LINES  = vfc_pkg::FRAME_LINES_DEF,
  parameter int unsigned PACKET_BYTES = vfc_pkg::PACKET_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [vfc_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] spi_byte
  input  logic                               s_axis_tuser,  // [0] mode
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [12:0] pixel_addr, [28:13] pixel_value, [29] power_on, [31:30] phase
  output logic [vfc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tuser,  // [0] pixel_write
  output logic                               m_axis_tlast,  // frame_done
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  vfc_pkg::cfg_t cfg;
  vfc_pkg::res_t res;
  logic          accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  vfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // packet parser, error tracking and power sequencing
  vfc_core #(
    .LINE_PIXELS  (LINE_PIXELS),
    .FRAME_LINES  (FRAME_LINES),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .mode     (s_axis_tuser),
    .spi_byte (s_axis_tdata),
    .cfg      (cfg),
    .res      (res)
  );

  vfc_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (s_axis_tvalid),
    .load_ready    (s_axis_tready),
    .res           (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
